/* hw/rtl/feedforward_dynamic_range_compressor_top_defines.svh */
// Assertion helpers for the compressor top.
`ifndef FEEDFORWARD_DYNAMIC_RANGE_COMPRESSOR_TOP_DEFINES_SVH
`define FEEDFORWARD_DYNAMIC_RANGE_COMPRESSOR_TOP_DEFINES_SVH

// Check that post holds in the cycle after pre.
`define FDRC_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("fdrc: next-cycle check failed");

// Check that post holds in the same cycle as pre.
`define FDRC_ASSERT_NOW(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("fdrc: same-cycle check failed");

`endif

/* hw/rtl/fdrc_pkg.sv */
`default_nettype none
package fdrc_pkg;

   localparam int CHANNELS    = 8;
   localparam int SLOT_W      = $clog2(CHANNELS);
   localparam int CH_W        = 3;
   localparam int SAMPLE_BITS = 24;
   localparam int ENV_W       = 24;
   localparam int LOG_W       = 21;
   localparam int MANT_W      = 31;
   localparam int POS_W       = 5;

   localparam int REQ_DATA_W  = 2 * SAMPLE_BITS;
   localparam int REQ_USER_W  = CH_W + 1;
   localparam int RSP_DATA_W  = SAMPLE_BITS;
   localparam int RSP_USER_W  = CH_W;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 24;

   // Threshold at or below this value forces zero output when the envelope is above it.
   localparam logic [ENV_W-1:0] ZERO_GAIN_LIMIT = ENV_W'((2 ** (SAMPLE_BITS - 1)) / 10000);

   localparam logic [23:0] THR_RESET  = 24'd4194304;
   localparam logic [16:0] GEXP_RESET = 17'h18000;
   localparam logic [23:0] ATT_RESET  = 24'd16759743;
   localparam logic [23:0] REL_RESET  = 24'd16775469;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_THRESHOLD = 2'd0,
      REG_GAIN_EXP  = 2'd1,
      REG_ATTACK    = 2'd2,
      REG_RELEASE   = 2'd3
   } reg_index_type;

   typedef enum logic [9:0] {
      ST_IDLE  = 10'b00_0000_0001,
      ST_ENV1  = 10'b00_0000_0010,
      ST_ENV2  = 10'b00_0000_0100,
      ST_LOGE  = 10'b00_0000_1000,
      ST_LOGT  = 10'b00_0001_0000,
      ST_EXPO  = 10'b00_0010_0000,
      ST_FRAC  = 10'b00_0100_0000,
      ST_SCALE = 10'b00_1000_0000,
      ST_SHIFT = 10'b01_0000_0000,
      ST_FIN   = 10'b10_0000_0000
   } state_type;

   typedef struct packed {
      logic [POS_W-1:0]  top;
      logic [MANT_W-1:0] mant;
   } norm_type;

   typedef logic [MANT_W-1:0] exp_tab_type [16];

   // 2^(2^-(k+1)) in Q1.30, each the floor square root of the one before, from 2.0.
   function automatic exp_tab_type build_exp_tab();
      exp_tab_type t;
      logic [63:0] prev;
      logic [63:0] v;
      logic [63:0] r;
      logic [63:0] b;
      prev = 64'h8000_0000;
      for (int k = 0; k < 16; k++) begin
         v = prev << 30;
         r = '0;
         for (int i = 31; i >= 0; i--) begin
            b = 64'd1 << (2 * i);
            if (v >= r + b) begin
               v = v - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
         end
         t[k] = r[MANT_W-1:0];
         prev = r;
      end
      return t;
   endfunction

   localparam exp_tab_type EXP_TAB = build_exp_tab();

endpackage
`default_nettype wire

/* hw/rtl/fdrc_norm.sv */
`default_nettype none
module fdrc_norm (
   input  logic [fdrc_pkg::ENV_W-1:0] norm_x,
   output fdrc_pkg::norm_type         norm_o
);
   import fdrc_pkg::*;

   logic [POS_W-1:0] pos;

   // Find the top set bit and left-align the value to Q1.30.
   always_comb begin
      pos = '0;
      for (int i = 1; i < ENV_W; i++) begin
         if (norm_x[i]) begin
            pos = POS_W'(i);
         end
      end
      norm_o.top  = pos;
      norm_o.mant = MANT_W'(norm_x) << (POS_W'(30) - pos);
   end

endmodule
`default_nettype wire

/* hw/rtl/feedforward_dynamic_range_compressor_top.sv */
`default_nettype none
`include "feedforward_dynamic_range_compressor_top_defines.svh"
// Feed-forward peak compressor. Each request carries one Q1.23 sample, its
// channel and an optional sidechain sample; the block updates that channel's
// peak envelope (attack or release smoothing) and returns the sample scaled by
// (env/threshold)^gain_exponent when the envelope is above the threshold,
// unchanged otherwise; an envelope above a threshold at or below 0.0001 full
// scale gives zero instead. All multiplication runs through one 32x32 multiplier
// under a small sequencer, one request at a time. A request that passes
// unchanged or goes to zero runs two envelope steps and the output load; one
// that needs a gain runs two envelope steps, two 16-step log2 squaring loops,
// one exponent product, a 16-step exp2 product chain, the sample product, the
// final shift and the output load. The input is ready again once the result
// is loaded. The result sits in an output register, so the next request is
// taken while it waits; a result still waiting when the next one is done
// holds the sequencer in its last step. The CSR port is always ready; write
// it only while the block is idle.
module feedforward_dynamic_range_compressor_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [fdrc_pkg::REQ_DATA_W-1:0]   req_tdata,  // sample_in, sidechain_sample
   input  logic [fdrc_pkg::REQ_USER_W-1:0]   req_tuser,  // channel_index, use_sidechain
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [fdrc_pkg::RSP_DATA_W-1:0]   rsp_tdata,  // sample_out
   output logic [fdrc_pkg::RSP_USER_W-1:0]   rsp_tuser,  // channel_out
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [fdrc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [fdrc_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import fdrc_pkg::*;

   // Sequencer and configuration
   state_type               state_ff, state_in;
   logic [ENV_W-1:0]        thr_ff, thr_in;
   logic [16:0]             gexp_ff, gexp_in;
   logic [23:0]             att_ff, att_in;
   logic [23:0]             rel_ff, rel_in;
   logic [ENV_W-1:0]        env_ff [CHANNELS];
   logic [ENV_W-1:0]        env_in [CHANNELS];

   // Working registers for the request in flight
   logic [CH_W-1:0]         ch_ff, ch_in;
   logic [SLOT_W-1:0]       slot_ff, slot_in;
   logic [SAMPLE_BITS-1:0]  s_ff, s_in;
   logic [SAMPLE_BITS-1:0]  mag_ff, mag_in;
   logic [23:0]             coeff_ff, coeff_in;
   logic [47:0]             acc_ff, acc_in;
   logic [MANT_W-1:0]       m_ff, m_in;
   logic [LOG_W-1:0]        lr_ff, lr_in;
   logic [LOG_W-1:0]        le_ff, le_in;
   logic [3:0]              cnt_ff, cnt_in;
   logic [23:0]             y_ff, y_in;
   logic [MANT_W-1:0]       g_ff, g_in;
   logic [54:0]             sp_ff, sp_in;
   logic [SAMPLE_BITS-1:0]  res_ff, res_in;

   // Output register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]   rsp_data_ff, rsp_data_in;
   logic [RSP_USER_W-1:0]   rsp_user_ff, rsp_user_in;

   // Shared multiplier and helpers
   logic [31:0]             mul_a, mul_b;
   logic [63:0]             prod;
   logic [ENV_W-1:0]        norm_x;
   norm_type                norm_r;
   logic [SAMPLE_BITS-1:0]  req_s, req_sc, req_det;
   logic [47:0]             env_sum;
   logic [ENV_W-1:0]        env_new;
   logic [31:0]             sq;
   logic [LOG_W-1:0]        lr_set;
   logic [21:0]             diff, dmag;
   logic [16:0]             gmag;
   logic [39:0]             pn;
   logic [SAMPLE_BITS-1:0]  smag;
   logic signed [7:0]       ip;
   logic [8:0]              sh;
   logic [55:0]             v;
   logic [SAMPLE_BITS-1:0]  vc;
   logic                    rsp_free;

   fdrc_norm u_norm (
      .norm_x (norm_x),
      .norm_o (norm_r)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   assign req_s   = req_tdata[SAMPLE_BITS-1:0];
   assign req_sc  = req_tdata[REQ_DATA_W-1:SAMPLE_BITS];
   assign req_det = req_tuser[CH_W] ? req_sc : req_s;

   assign prod    = 64'(mul_a) * 64'(mul_b);
   assign env_sum = acc_ff + prod[47:0];
   assign env_new = env_sum[47:24];
   assign sq      = prod[61:30];
   assign lr_set  = lr_ff | (LOG_W'(1) << cnt_ff);
   assign diff    = 22'(le_ff) - 22'(lr_ff);
   assign dmag    = diff[21] ? 22'(0) - diff : diff;
   assign gmag    = gexp_ff[16] ? 17'(0) - gexp_ff : gexp_ff;
   assign smag    = s_ff[SAMPLE_BITS-1] ? SAMPLE_BITS'(0) - s_ff : s_ff;
   assign norm_x  = (state_ff == ST_ENV2) ? env_new : thr_ff;

   // Feed the shared multiplier for the current step.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff) inside
         ST_ENV1: begin
            mul_a = 32'((mag_ff > env_ff[slot_ff]) ? att_ff : rel_ff);
            mul_b = 32'(env_ff[slot_ff]);
         end
         ST_ENV2: begin
            mul_a = 32'(25'h100_0000 - 25'(coeff_ff));
            mul_b = 32'(mag_ff);
         end
         ST_LOGE, ST_LOGT: begin
            mul_a = 32'(m_ff);
            mul_b = 32'(m_ff);
         end
         ST_EXPO: begin
            mul_a = 32'(gmag);
            mul_b = 32'(dmag);
         end
         ST_FRAC: begin
            mul_a = 32'(g_ff);
            mul_b = 32'(EXP_TAB[cnt_ff]);
         end
         ST_SCALE: begin
            mul_a = 32'(smag);
            mul_b = 32'(g_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // Final shift, clamp and sign restore of the scaled magnitude.
   always_comb begin
      ip = signed'(y_ff[23:16]);
      sh = 9'd30 - {ip[7], ip};
      if (ip >= 8'sd23) begin
         v = (sp_ff != '0) ? 56'h100_0000 : '0;
      end else if (sh[8:6] != 3'd0) begin
         v = '0;
      end else begin
         v = 56'(sp_ff >> sh[5:0]);
      end
      if (s_ff[SAMPLE_BITS-1]) begin
         vc = (v > 56'h80_0000) ? 24'h80_0000 : v[23:0];
         vc = 24'(0) - vc;
      end else begin
         vc = (v > 56'h7F_FFFF) ? 24'h7F_FFFF : v[23:0];
      end
   end

   always_comb begin
      state_in     = state_ff;
      thr_in       = thr_ff;
      gexp_in      = gexp_ff;
      att_in       = att_ff;
      rel_in       = rel_ff;
      env_in       = env_ff;
      ch_in        = ch_ff;
      slot_in      = slot_ff;
      s_in         = s_ff;
      mag_in       = mag_ff;
      coeff_in     = coeff_ff;
      acc_in       = acc_ff;
      m_in         = m_ff;
      lr_in        = lr_ff;
      le_in        = le_ff;
      cnt_in       = cnt_ff;
      y_in         = y_ff;
      g_in         = g_ff;
      sp_in        = sp_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      pn           = '0;

      // Drop the result once the consumer takes it.
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_valid) begin
         unique case (reg_index_type'(csr_index))
            REG_THRESHOLD: thr_in  = csr_wdata;
            REG_GAIN_EXP:  gexp_in = csr_wdata[16:0];
            REG_ATTACK:    att_in  = csr_wdata;
            REG_RELEASE:   rel_in  = csr_wdata;
            default:       thr_in  = thr_ff;
         endcase
      end

      unique case (state_ff) inside
         ST_IDLE: begin
            if (req_tvalid) begin
               ch_in    = req_tuser[CH_W-1:0];
               slot_in  = SLOT_W'(req_tuser[CH_W-1:0] % CHANNELS);
               s_in     = req_s;
               mag_in   = req_det[SAMPLE_BITS-1] ? SAMPLE_BITS'(0) - req_det : req_det;
               state_in = ST_ENV1;
            end
         end
         ST_ENV1: begin
            coeff_in = mul_a[23:0];
            acc_in   = prod[47:0];
            state_in = ST_ENV2;
         end
         ST_ENV2: begin
            env_in[slot_ff] = env_new;
            if (env_new <= thr_ff) begin
               res_in   = s_ff;
               state_in = ST_FIN;
            end else if (thr_ff <= ZERO_GAIN_LIMIT) begin
               res_in   = '0;
               state_in = ST_FIN;
            end else begin
               m_in     = norm_r.mant;
               lr_in    = {norm_r.top, 16'd0};
               cnt_in   = 4'd15;
               state_in = ST_LOGE;
            end
         end
         ST_LOGE, ST_LOGT: begin
            if (sq[31]) begin
               m_in  = sq[31:1];
               lr_in = lr_set;
            end else begin
               m_in  = sq[30:0];
            end
            cnt_in = cnt_ff - 4'd1;
            if (cnt_ff == 4'd0) begin
               if (state_ff == ST_LOGE) begin
                  // Hold log2(env), start log2(threshold).
                  le_in    = sq[31] ? lr_set : lr_ff;
                  m_in     = norm_r.mant;
                  lr_in    = {norm_r.top, 16'd0};
                  cnt_in   = 4'd15;
                  state_in = ST_LOGT;
               end else begin
                  state_in = ST_EXPO;
               end
            end
         end
         ST_EXPO: begin
            pn       = (gexp_ff[16] ^ diff[21]) ? 40'(0) - {1'b0, prod[38:0]}
                                                : {1'b0, prod[38:0]};
            y_in     = pn[39:16];
            g_in     = MANT_W'(1) << 30;
            cnt_in   = 4'd0;
            state_in = ST_FRAC;
         end
         ST_FRAC: begin
            // Multiply in 2^(2^-j) for each set fraction bit of weight 2^-j, highest first.
            if (y_ff[4'd15 - cnt_ff]) begin
               g_in = prod[60:30];
            end
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd15) begin
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            sp_in    = prod[54:0];
            state_in = ST_SHIFT;
         end
         ST_SHIFT: begin
            res_in   = vc;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               rsp_user_in  = ch_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         thr_ff       <= THR_RESET;
         gexp_ff      <= GEXP_RESET;
         att_ff       <= ATT_RESET;
         rel_ff       <= REL_RESET;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < CHANNELS; i++) begin
            env_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         thr_ff       <= thr_in;
         gexp_ff      <= gexp_in;
         att_ff       <= att_in;
         rel_ff       <= rel_in;
         rsp_valid_ff <= rsp_valid_in;
         env_ff       <= env_in;
      end
   end

   always_ff @(posedge clock) begin
      ch_ff       <= ch_in;
      slot_ff     <= slot_in;
      s_ff        <= s_in;
      mag_ff      <= mag_in;
      coeff_ff    <= coeff_in;
      acc_ff      <= acc_in;
      m_ff        <= m_in;
      lr_ff       <= lr_in;
      le_ff       <= le_in;
      cnt_ff      <= cnt_in;
      y_ff        <= y_in;
      g_ff        <= g_in;
      sp_ff       <= sp_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   // An accepted request starts the envelope update next cycle.
   `FDRC_ASSERT_NEXT(a_req_starts, req_tvalid && req_tready, state_ff == ST_ENV1)
   // A finished request loads the output register with its channel.
   `FDRC_ASSERT_NEXT(a_rsp_load, (state_ff == ST_FIN) && rsp_free, rsp_tvalid && (rsp_tuser == $past(ch_ff)))
   // The log mantissa stays normalized in [1, 2) throughout the squaring loop.
   `FDRC_ASSERT_NOW(a_mant_norm, (state_ff == ST_LOGE) || (state_ff == ST_LOGT), m_ff[30])

endmodule
`default_nettype wire
